// ===== hw/rtl/tsot_pkg.sv =====
// Shared types, widths and codes for the triangle versus clip-square overlap test.
package tsot_pkg;

  // Fraction bits and width of the coordinate format, and the width of the tolerance.
  localparam int unsigned CoordFracBits = 16;
  localparam int unsigned CoordW        = 24;
  localparam int unsigned TolW          = 16;

  // Edge normal components are differences of two coordinates.
  localparam int unsigned NormW = CoordW + 1;
  // |nx| + |ny| needs one more bit than a normal component magnitude.
  localparam int unsigned AbsSumW = NormW + 1;
  // One coordinate times one normal component.
  localparam int unsigned ProdW = CoordW + NormW;
  // Sum of two products.
  localparam int unsigned DotW = ProdW + 1;
  // Square half-extent on an edge axis: (|nx| + |ny|) scaled by 1.0.
  localparam int unsigned QmaxW = AbsSumW + CoordFracBits;
  // Signed width that holds both a dot product and a negated square bound.
  localparam int unsigned CmpW = ((DotW > QmaxW) ? DotW : QmaxW) + 1;
  // Signed width for the axis-aligned limits, 1.0 plus the tolerance.
  localparam int unsigned LimW = ((CoordW > CoordFracBits + 1) ? CoordW : CoordFracBits + 1) + 2;

  // Separating axis codes, in test priority order.
  typedef enum logic [2:0] {
    AXIS_NONE   = 3'd0,
    AXIS_LEFT   = 3'd1,
    AXIS_RIGHT  = 3'd2,
    AXIS_BOTTOM = 3'd3,
    AXIS_TOP    = 3'd4,
    AXIS_EDGE01 = 3'd5,
    AXIS_EDGE12 = 3'd6,
    AXIS_EDGE20 = 3'd7
  } axis_e;

  // One triangle vertex.
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } vertex_t;

  // Registered products and square bound of one edge axis.
  typedef struct packed {
    logic signed [ProdW-1:0] ax_nx;
    logic signed [ProdW-1:0] ay_ny;
    logic signed [ProdW-1:0] cx_nx;
    logic signed [ProdW-1:0] cy_ny;
    logic        [QmaxW-1:0] qmax;
  } edge_prod_t;

endpackage

// ===== hw/rtl/triangle_square_overlap_test_unit.sv =====
// Top level of the triangle versus clip-square overlap test: handshake, pipeline registers, priority.
// A transaction is held in the input, middle and result registers in turn before its result is presented.
// Throughput: one triangle per cycle while the output is not stalled; each of the three stages
// (input, edge products, result) advances whenever the stage after it is empty or advancing.
// Reset clears all stage valid flags and the tolerance register to zero; payload is not reset.
module triangle_square_overlap_test_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration register.
  input  logic                                cfg_we_i,
  input  logic [tsot_pkg::TolW-1:0]           cfg_wdata_i,
  // Input channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [tsot_pkg::CoordW-1:0]  first_x_i,
  input  logic signed [tsot_pkg::CoordW-1:0]  first_y_i,
  input  logic signed [tsot_pkg::CoordW-1:0]  second_x_i,
  input  logic signed [tsot_pkg::CoordW-1:0]  second_y_i,
  input  logic signed [tsot_pkg::CoordW-1:0]  third_x_i,
  input  logic signed [tsot_pkg::CoordW-1:0]  third_y_i,
  // Output channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                overlaps_o,
  output logic [2:0]                          separating_axis_o
);

  localparam logic signed [tsot_pkg::LimW-1:0] One =
    tsot_pkg::LimW'(1) << tsot_pkg::CoordFracBits;

  logic [tsot_pkg::TolW-1:0] tol_q;

  logic                  in_valid_q;
  tsot_pkg::vertex_t     v0_q, v1_q, v2_q;

  logic                  mid_valid_q;
  tsot_pkg::axis_e       mid_axis_q, mid_axis_d;
  tsot_pkg::edge_prod_t  e01_q, e12_q, e20_q;
  tsot_pkg::edge_prod_t  e01_d, e12_d, e20_d;

  logic                  out_valid_q;
  tsot_pkg::axis_e       out_axis_q, out_axis_d;

  logic                  out_ready, mid_ready, in_ready;
  logic signed [tsot_pkg::LimW-1:0] lo_lim, hi_lim;
  logic                  sep01, sep12, sep20;

  // Stage advance: each stage moves when the next one is empty or moving.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign mid_ready  = !mid_valid_q || out_ready;
  assign in_ready   = !in_valid_q || mid_ready;
  assign in_stall_o = !in_ready;

  // Tolerance register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Input register: valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Input register: vertices.
  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      v0_q <= '{x: first_x_i,  y: first_y_i};
      v1_q <= '{x: second_x_i, y: second_y_i};
      v2_q <= '{x: third_x_i,  y: third_y_i};
    end
  end

  // Axis-aligned limits, widened by the tolerance.
  assign lo_lim = -One - $signed(tsot_pkg::LimW'(tol_q));
  assign hi_lim =  One + $signed(tsot_pkg::LimW'(tol_q));

  // Axis-aligned tests in priority order left, right, bottom, top.
  always_comb begin
    if (tsot_pkg::LimW'(v0_q.x) < lo_lim && tsot_pkg::LimW'(v1_q.x) < lo_lim &&
        tsot_pkg::LimW'(v2_q.x) < lo_lim) begin
      mid_axis_d = tsot_pkg::AXIS_LEFT;
    end else if (tsot_pkg::LimW'(v0_q.x) > hi_lim && tsot_pkg::LimW'(v1_q.x) > hi_lim &&
                 tsot_pkg::LimW'(v2_q.x) > hi_lim) begin
      mid_axis_d = tsot_pkg::AXIS_RIGHT;
    end else if (tsot_pkg::LimW'(v0_q.y) < lo_lim && tsot_pkg::LimW'(v1_q.y) < lo_lim &&
                 tsot_pkg::LimW'(v2_q.y) < lo_lim) begin
      mid_axis_d = tsot_pkg::AXIS_BOTTOM;
    end else if (tsot_pkg::LimW'(v0_q.y) > hi_lim && tsot_pkg::LimW'(v1_q.y) > hi_lim &&
                 tsot_pkg::LimW'(v2_q.y) > hi_lim) begin
      mid_axis_d = tsot_pkg::AXIS_TOP;
    end else begin
      mid_axis_d = tsot_pkg::AXIS_NONE;
    end
  end

  // Edge products for the edge normals 01, 12 and 20.
  tsot_edge_mul u_mul01 (.a_i(v0_q), .b_i(v1_q), .c_i(v2_q), .prod_o(e01_d));
  tsot_edge_mul u_mul12 (.a_i(v1_q), .b_i(v2_q), .c_i(v0_q), .prod_o(e12_d));
  tsot_edge_mul u_mul20 (.a_i(v2_q), .b_i(v0_q), .c_i(v1_q), .prod_o(e20_d));

  // Middle register: valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (mid_ready) begin
      mid_valid_q <= in_valid_q;
    end
  end

  // Middle register: axis-aligned outcome and edge products.
  always_ff @(posedge clk_i) begin
    if (mid_ready && in_valid_q) begin
      mid_axis_q <= mid_axis_d;
      e01_q      <= e01_d;
      e12_q      <= e12_d;
      e20_q      <= e20_d;
    end
  end

  // Edge interval compares.
  tsot_edge_cmp u_cmp01 (.prod_i(e01_q), .separates_o(sep01));
  tsot_edge_cmp u_cmp12 (.prod_i(e12_q), .separates_o(sep12));
  tsot_edge_cmp u_cmp20 (.prod_i(e20_q), .separates_o(sep20));

  // Final priority: axis-aligned outcome first, then edges in order.
  always_comb begin
    if (mid_axis_q != tsot_pkg::AXIS_NONE) begin
      out_axis_d = mid_axis_q;
    end else if (sep01) begin
      out_axis_d = tsot_pkg::AXIS_EDGE01;
    end else if (sep12) begin
      out_axis_d = tsot_pkg::AXIS_EDGE12;
    end else if (sep20) begin
      out_axis_d = tsot_pkg::AXIS_EDGE20;
    end else begin
      out_axis_d = tsot_pkg::AXIS_NONE;
    end
  end

  // Result register: valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= mid_valid_q;
    end
  end

  // Result register: separating axis.
  always_ff @(posedge clk_i) begin
    if (out_ready && mid_valid_q) begin
      out_axis_q <= out_axis_d;
    end
  end

  // Output transaction.
  assign out_valid_o       = out_valid_q;
  assign overlaps_o        = (out_axis_q == tsot_pkg::AXIS_NONE);
  assign separating_axis_o = 3'(out_axis_q);

endmodule

// ===== hw/rtl/tsot_edge_mul.sv =====
// First half of one edge-normal test: the normal, the four vertex products and the square bound.
module tsot_edge_mul (
  input  tsot_pkg::vertex_t    a_i,
  input  tsot_pkg::vertex_t    b_i,
  input  tsot_pkg::vertex_t    c_i,
  output tsot_pkg::edge_prod_t prod_o
);

  logic signed [tsot_pkg::NormW-1:0]   nx;
  logic signed [tsot_pkg::NormW-1:0]   ny;
  logic        [tsot_pkg::NormW-1:0]   nx_abs;
  logic        [tsot_pkg::NormW-1:0]   ny_abs;
  logic        [tsot_pkg::AbsSumW-1:0] abs_sum;

  // Edge normal n = (by - ay, ax - bx), exact in one extra bit.
  assign nx = tsot_pkg::NormW'(b_i.y) - tsot_pkg::NormW'(a_i.y);
  assign ny = tsot_pkg::NormW'(a_i.x) - tsot_pkg::NormW'(b_i.x);

  // Magnitudes of the normal; the most negative value cannot occur here.
  assign nx_abs  = nx[tsot_pkg::NormW-1] ? tsot_pkg::NormW'(-nx) : tsot_pkg::NormW'(nx);
  assign ny_abs  = ny[tsot_pkg::NormW-1] ? tsot_pkg::NormW'(-ny) : tsot_pkg::NormW'(ny);
  assign abs_sum = tsot_pkg::AbsSumW'(nx_abs) + tsot_pkg::AbsSumW'(ny_abs);

  // Vertex products for dot(a,n) and dot(c,n); summed after the pipeline register.
  assign prod_o.ax_nx = tsot_pkg::ProdW'(a_i.x) * tsot_pkg::ProdW'(nx);
  assign prod_o.ay_ny = tsot_pkg::ProdW'(a_i.y) * tsot_pkg::ProdW'(ny);
  assign prod_o.cx_nx = tsot_pkg::ProdW'(c_i.x) * tsot_pkg::ProdW'(nx);
  assign prod_o.cy_ny = tsot_pkg::ProdW'(c_i.y) * tsot_pkg::ProdW'(ny);

  // Square half-extent on this axis, scaled by 1.0.
  assign prod_o.qmax = tsot_pkg::QmaxW'(abs_sum) << tsot_pkg::CoordFracBits;

endmodule

// ===== hw/rtl/tsot_edge_cmp.sv =====
// Second half of one edge-normal test: dot products, triangle interval and the overlap compare.
module tsot_edge_cmp (
  input  tsot_pkg::edge_prod_t prod_i,
  output logic                 separates_o
);

  logic signed [tsot_pkg::CmpW-1:0] dot_a;
  logic signed [tsot_pkg::CmpW-1:0] dot_c;
  logic signed [tsot_pkg::CmpW-1:0] lo;
  logic signed [tsot_pkg::CmpW-1:0] hi;
  logic signed [tsot_pkg::CmpW-1:0] qmax_s;

  // Dot products of the edge start and the opposite vertex with the normal.
  assign dot_a = tsot_pkg::CmpW'(prod_i.ax_nx) + tsot_pkg::CmpW'(prod_i.ay_ny);
  assign dot_c = tsot_pkg::CmpW'(prod_i.cx_nx) + tsot_pkg::CmpW'(prod_i.cy_ny);

  // Triangle interval on the axis.
  assign lo = (dot_a < dot_c) ? dot_a : dot_c;
  assign hi = (dot_a < dot_c) ? dot_c : dot_a;

  // The bound is non-negative, so zero extension keeps its value.
  assign qmax_s = $signed(tsot_pkg::CmpW'(prod_i.qmax));

  // A zero-length edge gives both dot products and the bound as zero, so it never separates.
  assign separates_o = (qmax_s < lo) || (-qmax_s > hi);

endmodule
